// ===== rtl/core/length_header_frame_decoder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Length header frame decoder: assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LENGTH_HEADER_FRAME_DECODER_UNIT_DEFINES_SVH
`define LENGTH_HEADER_FRAME_DECODER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LHFD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LHFD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lhfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length header frame decoder package
// Sizes, character codes, result kinds and the types passed between the
// front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package lhfd_pkg;

   // Table size and length width.
   localparam int MAX_WORDS   = 32;
   localparam int LEN_BITS    = 16;
   localparam int CNT_BITS    = $clog2(MAX_WORDS + 1);
   localparam int ADDR_BITS   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int TOTAL_BITS  = LEN_BITS + CNT_BITS;
   localparam int ACC_BITS    = LEN_BITS + 4;

   // Fixed field widths.
   localparam int BYTE_BITS   = 8;
   localparam int KIND_BITS   = 2;
   localparam int IDX_BITS    = 5;

   // Command queue.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Header characters.
   localparam logic [BYTE_BITS-1:0] CH_HASH = 8'h23;
   localparam logic [BYTE_BITS-1:0] CH_DASH = 8'h2D;
   localparam logic [BYTE_BITS-1:0] CH_ZERO = 8'h30;
   localparam logic [BYTE_BITS-1:0] CH_NINE = 8'h39;

   // Result kinds.
   localparam logic [KIND_BITS-1:0] KIND_DATA       = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_EMPTY_WORD = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_EMPTY_MSG  = 2'd2;

   // One queue entry: either the start of a message or a payload byte.
   typedef struct packed {
      logic                 is_start;
      logic [BYTE_BITS-1:0] data;
      logic [CNT_BITS-1:0]  count;
      logic                 ovf;
   } lhfd_cmd_type;

   // Write port of the length table.
   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      logic [LEN_BITS-1:0]  len;
   } lhfd_tbl_wr_type;

endpackage

// ===== rtl/core/lhfd_queue.sv =====
`timescale 1ns / 1ps
`include "length_header_frame_decoder_unit_defines.svh"
// ----------------------------------------------------------------------------
// Length header frame decoder command queue
// Short FIFO of commands from the front end to the back end.
// ----------------------------------------------------------------------------
module lhfd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lhfd_pkg::lhfd_cmd_type push_data,
   input  logic                  pop,
   output lhfd_pkg::lhfd_cmd_type head,
   output logic                  empty,
   output logic                  full
);
   import lhfd_pkg::*;

   lhfd_cmd_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] fill_ff, fill_in;

   assign empty = (fill_ff == '0);
   assign full  = (fill_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `LHFD_ASSERT_IMP(a_no_push_when_full, push && !pop, !full, "queue pushed while full")
   `LHFD_ASSERT_IMP(a_no_pop_when_empty, pop, !empty, "queue popped while empty")

endmodule

// ===== rtl/core/lhfd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length header frame decoder front end
// Parses the header, fills the length table and forwards payload bytes.
// ----------------------------------------------------------------------------
module lhfd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_in_byte,
   input  logic                      q_full,
   input  logic                      msg_done,
   output logic                      push,
   output lhfd_pkg::lhfd_cmd_type    push_data,
   output lhfd_pkg::lhfd_tbl_wr_type tbl_wr
);
   import lhfd_pkg::*;

   localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

   logic                  phase_ff, phase_in;
   logic [LEN_BITS-1:0]   acc_ff, acc_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [TOTAL_BITS-1:0] remain_ff, remain_in;
   logic                  busy_ff, busy_in;

   logic                  is_digit;
   logic                  is_dash;
   logic                  is_hash;
   logic                  accept;
   logic                  room;
   logic [3:0]            digit;
   logic [ACC_BITS-1:0]   acc_wide;

   // Byte classification.
   assign is_digit = req_in_byte inside {[CH_ZERO:CH_NINE]};
   assign is_dash  = (req_in_byte == CH_DASH);
   assign is_hash  = (req_in_byte == CH_HASH);
   assign room     = (count_ff < CNT_BITS'(MAX_WORDS));
   assign digit    = 4'(req_in_byte - CH_ZERO);
   assign acc_wide = (ACC_BITS'(acc_ff) << 3) + (ACC_BITS'(acc_ff) << 1) + ACC_BITS'(digit);

   // Table writes and message starts wait until the previous message is done.
   always_comb begin
      if (phase_ff) begin
         req_ready = !q_full;
      end else if (is_hash) begin
         req_ready = !busy_ff && !q_full;
      end else if (is_dash) begin
         req_ready = !busy_ff;
      end else begin
         req_ready = 1'b1;
      end
   end

   assign accept = req_valid && req_ready;

   // Commands towards the back end.
   assign push               = accept && (phase_ff || is_hash);
   assign push_data.is_start = !phase_ff;
   assign push_data.data     = req_in_byte;
   assign push_data.count    = count_ff;
   assign push_data.ovf      = ovf_ff;

   assign tbl_wr.en   = accept && !phase_ff && is_dash && room;
   assign tbl_wr.addr = count_ff[ADDR_BITS-1:0];
   assign tbl_wr.len  = acc_ff;

   // Header parsing and payload length tracking.
   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      total_in  = total_ff;
      remain_in = remain_ff;
      busy_in   = busy_ff;
      if (msg_done) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         if (phase_ff) begin
            remain_in = remain_ff - 1'b1;
            if (remain_ff == TOTAL_BITS'(1)) begin
               phase_in = 1'b0;
            end
         end else if (is_digit) begin
            acc_in = (acc_wide > ACC_BITS'(LEN_MAX)) ? LEN_MAX : acc_wide[LEN_BITS-1:0];
         end else if (is_dash) begin
            if (room) begin
               count_in = count_ff + 1'b1;
               total_in = total_ff + TOTAL_BITS'(acc_ff);
            end else begin
               ovf_in = 1'b1;
            end
            acc_in = '0;
         end else if (is_hash) begin
            busy_in   = 1'b1;
            acc_in    = '0;
            count_in  = '0;
            ovf_in    = 1'b0;
            total_in  = '0;
            remain_in = total_ff;
            phase_in  = (total_ff != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 1'b0;
         acc_ff    <= '0;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         total_ff  <= '0;
         remain_ff <= '0;
         busy_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         total_ff  <= total_in;
         remain_ff <= remain_in;
         busy_ff   <= busy_in;
      end
   end

endmodule

// ===== rtl/core/lhfd_back.sv =====
`timescale 1ns / 1ps
`include "length_header_frame_decoder_unit_defines.svh"
// ----------------------------------------------------------------------------
// Length header frame decoder back end
// Walks the length table, tags payload bytes and emits empty-word and
// empty-message results into the output register.
// ----------------------------------------------------------------------------
module lhfd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  lhfd_pkg::lhfd_tbl_wr_type tbl_wr,
   input  lhfd_pkg::lhfd_cmd_type    q_head,
   input  logic                      q_empty,
   output logic                      q_pop,
   output logic                      msg_done,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_kind,
   output logic [7:0]                rsp_out_byte,
   output logic [4:0]                rsp_word_index,
   output logic                      rsp_word_last,
   output logic                      rsp_message_last,
   output logic                      rsp_overflow
);
   import lhfd_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_DATA   = 2'd2;

   logic [LEN_BITS-1:0]  len_mem [MAX_WORDS];
   logic [LEN_BITS-1:0]  rd_len_ff;
   logic [ADDR_BITS-1:0] rd_addr;

   logic [1:0]           state_ff, state_in;
   logic [CNT_BITS-1:0]  cur_ff, cur_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic [LEN_BITS-1:0]  left_ff, left_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_BITS-1:0] rsp_kind_ff, rsp_kind_in;
   logic [BYTE_BITS-1:0] rsp_out_byte_ff, rsp_out_byte_in;
   logic [IDX_BITS-1:0]  rsp_word_index_ff, rsp_word_index_in;
   logic                 rsp_word_last_ff, rsp_word_last_in;
   logic                 rsp_message_last_ff, rsp_message_last_in;
   logic                 rsp_overflow_ff, rsp_overflow_in;

   logic                 out_free;
   logic                 load;
   logic [CNT_BITS-1:0]  cur_next;
   logic                 is_last;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cur_next = cur_ff + 1'b1;
   assign is_last  = (cur_next >= count_ff);
   assign rd_addr  = cur_in[ADDR_BITS-1:0];

   // Sequencer over the words of one message.
   always_comb begin
      state_in            = state_ff;
      cur_in              = cur_ff;
      count_in            = count_ff;
      ovf_in              = ovf_ff;
      left_in             = left_ff;
      q_pop               = 1'b0;
      msg_done            = 1'b0;
      load                = 1'b0;
      rsp_kind_in         = KIND_DATA;
      rsp_out_byte_in     = '0;
      rsp_word_index_in   = IDX_BITS'(cur_ff);
      rsp_word_last_in    = 1'b0;
      rsp_message_last_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (q_head.count == '0) begin
                  if (out_free) begin
                     q_pop               = 1'b1;
                     load                = 1'b1;
                     ovf_in              = q_head.ovf;
                     rsp_kind_in         = KIND_EMPTY_MSG;
                     rsp_word_index_in   = '0;
                     rsp_message_last_in = 1'b1;
                     msg_done            = 1'b1;
                  end
               end else begin
                  q_pop    = 1'b1;
                  count_in = q_head.count;
                  ovf_in   = q_head.ovf;
                  cur_in   = '0;
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            if (rd_len_ff == '0) begin
               if (out_free) begin
                  load                = 1'b1;
                  rsp_kind_in         = KIND_EMPTY_WORD;
                  rsp_word_last_in    = 1'b1;
                  rsp_message_last_in = is_last;
                  if (is_last) begin
                     msg_done = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     cur_in = cur_next;
                  end
               end
            end else begin
               left_in  = rd_len_ff;
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (!q_empty && out_free) begin
               q_pop           = 1'b1;
               load            = 1'b1;
               rsp_out_byte_in = q_head.data;
               if (left_ff > LEN_BITS'(1)) begin
                  left_in = left_ff - 1'b1;
               end else begin
                  rsp_word_last_in    = 1'b1;
                  rsp_message_last_in = is_last;
                  if (is_last) begin
                     msg_done = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     cur_in   = cur_next;
                     state_in = ST_LOOKUP;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_overflow_in = ovf_in;
      rsp_valid_in    = load || (rsp_valid_ff && !rsp_ready);
   end

   // Length table: written by the front end, read with a registered port.
   always_ff @(posedge clock) begin
      if (tbl_wr.en) begin
         len_mem[tbl_wr.addr] <= tbl_wr.len;
      end
      rd_len_ff <= len_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload and byte counter need no reset.
   always_ff @(posedge clock) begin
      left_ff <= left_in;
      if (load) begin
         rsp_kind_ff         <= rsp_kind_in;
         rsp_out_byte_ff     <= rsp_out_byte_in;
         rsp_word_index_ff   <= rsp_word_index_in;
         rsp_word_last_ff    <= rsp_word_last_in;
         rsp_message_last_ff <= rsp_message_last_in;
         rsp_overflow_ff     <= rsp_overflow_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_out_byte     = rsp_out_byte_ff;
   assign rsp_word_index   = rsp_word_index_ff;
   assign rsp_word_last    = rsp_word_last_ff;
   assign rsp_message_last = rsp_message_last_ff;
   assign rsp_overflow     = rsp_overflow_ff;

   `LHFD_ASSERT_IMP(a_msg_last_ends_word, rsp_valid_ff && rsp_message_last_ff && (rsp_kind_ff != KIND_EMPTY_MSG), rsp_word_last_ff, "message end without word end")
   `LHFD_ASSERT_IMP(a_idle_sees_start, (state_ff == ST_IDLE) && !q_empty, q_head.is_start, "payload byte outside a message")
   `LHFD_ASSERT_IMP(a_word_in_range, state_ff != ST_IDLE, cur_ff < count_ff, "word index beyond word count")

endmodule

// ===== rtl/core/length_header_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
// A payload byte passes through the command queue and the output register before it reaches rsp_valid.
// Throughput: one byte per cycle within a word while bytes are queued and the output is not stalled.
// Each word start and each empty word passes through the back-end lookup state; '#' opens the message.
// A '-' or '#' of the next header waits until the back end has closed the message.
// Reset is synchronous and clears all control state; the length table is not cleared.
// ----------------------------------------------------------------------------
// Length header frame decoder
// Decodes a length-prefixed word list: the front end parses the header into
// a length table, the back end tags each payload byte with its word.
// ----------------------------------------------------------------------------
module length_header_frame_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [4:0] rsp_word_index,
   output logic       rsp_word_last,
   output logic       rsp_message_last,
   output logic       rsp_overflow
);
   import lhfd_pkg::*;

   lhfd_cmd_type    push_data;
   lhfd_cmd_type    q_head;
   lhfd_tbl_wr_type tbl_wr;
   logic            push;
   logic            q_pop;
   logic            q_empty;
   logic            q_full;
   logic            msg_done;

   // Header parser and payload forwarder.
   lhfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .msg_done    (msg_done),
      .push        (push),
      .push_data   (push_data),
      .tbl_wr      (tbl_wr)
   );

   // Decouples the front end from the back end.
   lhfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // Word sequencer and result register.
   lhfd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .tbl_wr           (tbl_wr),
      .q_head           (q_head),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .msg_done         (msg_done),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_word_index   (rsp_word_index),
      .rsp_word_last    (rsp_word_last),
      .rsp_message_last (rsp_message_last),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

// ===== tb/length_header_frame_decoder_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length header frame decoder testbench
// Streams headers and payloads into the decoder one byte per transfer, under
// random idling on both channels, and checks every result in order against
// a behavioural decode of the same byte stream.
// ----------------------------------------------------------------------------
module length_header_frame_decoder_unit_test;
   import lhfd_pkg::*;

   localparam int CLK_HALF        = 2;
   localparam int RESET_CYCLES    = 9;
   localparam int RANDOM_ITEMS    = 330;
   localparam int QUIET_ITEMS     = 60;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int STALL_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 16;
   localparam int PRINT_LIMIT     = 40;
   localparam int DIR_ROWS        = 24;
   localparam int LEN_MAX         = (1 << LEN_BITS) - 1;

   // One result as the decoder presents it.
   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [BYTE_BITS-1:0] data;
      logic [IDX_BITS-1:0]  word;
      logic                 wlast;
      logic                 mlast;
      logic                 ovf;
   } frame_rsp_type;

   // One directed byte, with its single result written out where it is obvious.
   typedef struct packed {
      logic [BYTE_BITS-1:0] in_byte;
      logic                 typed;
      frame_rsp_type        rsp;
   } stim_row_type;

   localparam frame_rsp_type NO_RSP = '0;

   localparam stim_row_type DIR_TAB [DIR_ROWS] = '{
      // An empty header closes at once with the empty-message result.
      '{CH_HASH, 1'b1, '{KIND_EMPTY_MSG, 8'h00, 5'd0, 1'b0, 1'b1, 1'b0}},
      // A single zero-length word.
      '{"0",     1'b0, NO_RSP},
      '{CH_DASH, 1'b0, NO_RSP},
      '{CH_HASH, 1'b1, '{KIND_EMPTY_WORD, 8'h00, 5'd0, 1'b1, 1'b1, 1'b0}},
      // Lengths 2, 0 and 1 (leading zero), stray header bytes, dropped digits.
      '{"2",     1'b0, NO_RSP},
      '{"x",     1'b0, NO_RSP},
      '{8'h00,   1'b0, NO_RSP},
      '{CH_DASH, 1'b0, NO_RSP},
      '{"0",     1'b0, NO_RSP},
      '{CH_DASH, 1'b0, NO_RSP},
      '{"0",     1'b0, NO_RSP},
      '{"1",     1'b0, NO_RSP},
      '{CH_DASH, 1'b0, NO_RSP},
      '{"1",     1'b0, NO_RSP},
      '{"9",     1'b0, NO_RSP},
      '{CH_HASH, 1'b0, NO_RSP},
      // Payload: header characters are plain data here.
      '{CH_HASH, 1'b0, NO_RSP},
      '{CH_DASH, 1'b0, NO_RSP},
      '{8'hFF,   1'b1, '{KIND_DATA, 8'hFF, 5'd2, 1'b1, 1'b1, 1'b0}},
      // One byte word after an ignored all-ones header byte.
      '{8'hFF,   1'b0, NO_RSP},
      '{"1",     1'b0, NO_RSP},
      '{CH_DASH, 1'b0, NO_RSP},
      '{CH_HASH, 1'b0, NO_RSP},
      '{8'h00,   1'b1, '{KIND_DATA, 8'h00, 5'd0, 1'b1, 1'b1, 1'b0}}
   };

   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   logic [BYTE_BITS-1:0] req_in_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   logic [KIND_BITS-1:0] rsp_kind;
   logic [BYTE_BITS-1:0] rsp_out_byte;
   logic [IDX_BITS-1:0]  rsp_word_index;
   logic                 rsp_word_last;
   logic                 rsp_message_last;
   logic                 rsp_overflow;

   // Results predicted but not yet seen, oldest first.
   frame_rsp_type frame_q [$];

   int  mismatches    = 0;
   int  rsp_seen      = 0;
   int  decoded_items = 0;
   int  stall_cycles  = 0;
   int  req_idle_rate = 10;
   int  rsp_idle_rate = 10;
   bit  quiet         = 1'b0;
   bit  hold_off_req  = 1'b0;

   // Decoder state as the byte stream implies it.
   logic                dec_in_payload = 1'b0;
   logic [LEN_BITS-1:0] dec_acc        = '0;
   logic [LEN_BITS-1:0] dec_len [MAX_WORDS];
   int                  dec_words      = 0;
   int                  dec_cur        = 0;
   logic [LEN_BITS-1:0] dec_left       = '0;
   logic                dec_ovf        = 1'b0;

   length_header_frame_decoder_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_word_index   (rsp_word_index),
      .rsp_word_last    (rsp_word_last),
      .rsp_message_last (rsp_message_last),
      .rsp_overflow     (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < PRINT_LIMIT) begin
         $display("result %0d: %s is %0h, expected %0h", rsp_seen, what, got, want);
      end
      mismatches++;
   endtask

   function automatic void push_rsp(input logic [KIND_BITS-1:0] kind,
                                    input logic [BYTE_BITS-1:0] data, input int word,
                                    input logic wlast);
      frame_rsp_type r;
      r.kind  = kind;
      r.data  = data;
      r.word  = IDX_BITS'(word);
      r.wlast = wlast;
      r.mlast = 1'b0;
      r.ovf   = dec_ovf;
      frame_q = {frame_q, r};
   endfunction

   // Skip zero-length words, then open the next word or close the message.
   // The base is the queue size before this byte's results were added.
   function automatic void open_next_word(input int base);
      while (dec_cur < dec_words && dec_len[dec_cur] == '0) begin
         push_rsp(KIND_EMPTY_WORD, '0, dec_cur, 1'b1);
         dec_cur++;
      end
      if (dec_cur >= dec_words) begin
         if (frame_q.size() == base) begin
            push_rsp(KIND_EMPTY_MSG, '0, 0, 1'b0);
         end
         frame_q[frame_q.size() - 1].mlast = 1'b1;
         dec_in_payload = 1'b0;
         dec_acc        = '0;
         dec_words      = 0;
         dec_cur        = 0;
         dec_left       = '0;
         dec_ovf        = 1'b0;
      end else begin
         dec_left       = dec_len[dec_cur];
         dec_in_payload = 1'b1;
      end
   endfunction

   // Advances the decode by one byte; returns 0 for a header byte that is ignored.
   function automatic bit decode_byte(input logic [BYTE_BITS-1:0] b);
      int base;
      int acc_next;
      bit used;
      base = frame_q.size();
      used = 1'b1;
      if (!dec_in_payload) begin
         if (b >= CH_ZERO && b <= CH_NINE) begin
            acc_next = int'(dec_acc) * 10 + int'(b - CH_ZERO);
            dec_acc  = (acc_next > LEN_MAX) ? LEN_BITS'(LEN_MAX) : LEN_BITS'(acc_next);
         end else if (b == CH_DASH) begin
            if (dec_words < MAX_WORDS) begin
               dec_len[dec_words] = dec_acc;
               dec_words++;
            end else begin
               dec_ovf = 1'b1;
            end
            dec_acc = '0;
         end else if (b == CH_HASH) begin
            dec_acc = '0;
            dec_cur = 0;
            open_next_word(base);
         end else begin
            used = 1'b0;
         end
      end else if (dec_left > LEN_BITS'(1)) begin
         dec_left--;
         push_rsp(KIND_DATA, b, dec_cur, 1'b0);
      end else begin
         dec_left = '0;
         push_rsp(KIND_DATA, b, dec_cur, 1'b1);
         dec_cur++;
         open_next_word(base);
      end
      return used;
   endfunction

   // Offers one byte, waits for its transfer and records what it should cause.
   task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic typed,
                            input frame_rsp_type typed_rsp);
      int base;
      if (!quiet && $urandom_range(0, 99) < req_idle_rate) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      base = frame_q.size();
      if (decode_byte(b)) decoded_items++;
      if (typed) begin
         while (frame_q.size() > base) void'(frame_q.pop_back());
         frame_q = {frame_q, typed_rsp};
      end
   endtask

   // Mostly well-formed messages with random lengths and contents; the rest are
   // short noise bursts or messages whose payload is cut short or overlong.
   task automatic send_random_message();
      logic [BYTE_BITS-1:0] msg [$];
      logic [BYTE_BITS-1:0] junk;
      string                digits;
      int                   sel;
      int                   words;
      int                   len;
      int                   payload;
      sel           = $urandom_range(0, 99);
      req_idle_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      rsp_idle_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      if (sel < 10) begin
         repeat ($urandom_range(1, 6)) begin
            junk = 8'($urandom_range(0, 255));
            if (junk >= CH_ZERO && junk <= CH_NINE) junk ^= 8'h40;
            msg = {msg, junk};
         end
      end else begin
         words   = ($urandom_range(0, 5) == 0) ? $urandom_range(MAX_WORDS - 2, MAX_WORDS + 4)
                                               : $urandom_range(0, 6);
         payload = 0;
         for (int i = 0; i < words; i++) begin
            if (words > 8) begin
               len = $urandom_range(0, 1);
            end else begin
               sel = $urandom_range(0, 19);
               len = (sel < 6) ? 0 : (sel < 17) ? $urandom_range(1, 4) : $urandom_range(5, 40);
            end
            if (i < MAX_WORDS) payload += len;
            if ($urandom_range(0, 9) == 0) msg = {msg, CH_ZERO};
            digits = $sformatf("%0d", len);
            for (int k = 0; k < digits.len(); k++) msg = {msg, BYTE_BITS'(digits[k])};
            if ($urandom_range(0, 9) == 0) begin
               junk = $urandom_range(0, 1) ? 8'($urandom_range(8'h3A, 8'hFF))
                                           : 8'($urandom_range(8'h00, 8'h22));
               msg  = {msg, junk};
            end
            msg = {msg, CH_DASH};
         end
         // Digits left after the last dash are dropped by the decoder.
         if ($urandom_range(0, 6) == 0) begin
            junk = 8'(int'(CH_ZERO) + $urandom_range(0, 9));
            msg  = {msg, junk};
         end
         msg = {msg, CH_HASH};
         // A payload of the wrong size throws the following message out of step.
         if ($urandom_range(0, 9) == 0) begin
            payload = payload + $urandom_range(0, 6) - 3;
            if (payload < 0) payload = 0;
         end
         repeat (payload) begin
            junk = 8'($urandom_range(0, 255));
            msg  = {msg, junk};
         end
      end
      foreach (msg[i]) send_byte(msg[i], 1'b0, NO_RSP);
   endtask

   // Sender: directed table, one saturating length, then random messages.
   initial begin : stimulus
      string long_head;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIR_ROWS; i++) begin
         send_byte(DIR_TAB[i].in_byte, DIR_TAB[i].typed, DIR_TAB[i].rsp);
      end
      // A length that saturates at the maximum and is then dropped as trailing
      // digits, leaving an empty message.
      long_head = "7000009#";
      for (int k = 0; k < long_head.len(); k++) send_byte(long_head[k], 1'b0, NO_RSP);
      decoded_items = 0;
      hold_off_req  = 1'b1;
      while (decoded_items < RANDOM_ITEMS) begin
         quiet = (decoded_items >= RANDOM_ITEMS - QUIET_ITEMS);
         send_random_message();
      end
      req_valid <= 1'b0;
      while (frame_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[length_header_frame_decoder_unit] OK");
      end else begin
         $display("[length_header_frame_decoder_unit] ERROR");
      end
      $finish;
   end

   // Receiver: random stalls, and one long hold-off that fills the decoder.
   initial begin : receiver
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 99) < rsp_idle_rate) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   // Each result transfer is compared with the oldest prediction.
   always @(posedge clock) begin : result_check
      frame_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_q.size() == 0) begin
            report_mismatch("unexpected result, kind", 32'(rsp_kind), '0);
         end else begin
            want = frame_q.pop_front();
            if (rsp_kind !== want.kind) begin
               report_mismatch("kind", 32'(rsp_kind), 32'(want.kind));
            end
            if (rsp_out_byte !== want.data) begin
               report_mismatch("out_byte", 32'(rsp_out_byte), 32'(want.data));
            end
            if (rsp_word_index !== want.word) begin
               report_mismatch("word_index", 32'(rsp_word_index), 32'(want.word));
            end
            if (rsp_word_last !== want.wlast) begin
               report_mismatch("word_last", 32'(rsp_word_last), 32'(want.wlast));
            end
            if (rsp_message_last !== want.mlast) begin
               report_mismatch("message_last", 32'(rsp_message_last), 32'(want.mlast));
            end
            if (rsp_overflow !== want.ovf) begin
               report_mismatch("overflow", 32'(rsp_overflow), 32'(want.ovf));
            end
         end
         rsp_seen++;
      end
   end

   // Watchdog: too long without a transfer on either channel ends the run.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[length_header_frame_decoder_unit] ERROR");
         $finish;
      end
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/lhfd_pkg.sv
rtl/core/lhfd_queue.sv
rtl/core/lhfd_front.sv
rtl/core/lhfd_back.sv
rtl/core/length_header_frame_decoder_unit.sv
tb/length_header_frame_decoder_unit_test.sv
